/* hw/rtl/mcu_pkg.sv */
// Shared types, constants and the command struct of the modulator cell update unit.
package mcu_pkg;

   localparam int CH_W     = 3;
   localparam int SAMPLE_W = 16;
   localparam int Q_W      = 15;
   localparam int AREA_W   = 10;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [Q_W-1:0] Q_ONE = 15'd16384;

   localparam int DEF_NUM_CHANNELS     = 8;
   localparam int DEF_MAX_WIDTH        = 200;
   localparam int DEF_MAX_HEIGHT       = 200;
   localparam int DEF_AREA_GROW_STEP   = 2;
   localparam int DEF_AREA_SHRINK_STEP = 2;
   localparam int DEF_MAX_CONC         = 16384;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_LEVEL_GAIN   = 3'd0,
      CFG_LEVEL_DROP   = 3'd1,
      CFG_PRODUCE_THR  = 3'd2,
      CFG_REDUCE_THR   = 3'd3,
      CFG_CONC_GAIN    = 3'd4,
      CFG_CONC_DROP    = 3'd5,
      CFG_WINDOW_LOW   = 3'd6,
      CFG_WINDOW_HIGH  = 3'd7
   } mcu_cfg_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } mcu_state_type;

   // load: take the request beat and read its entry; commit: write back and fill the output.
   typedef struct packed {
      logic load;
      logic commit;
   } mcu_cmd_type;

endpackage

/* hw/rtl/mcu_ctrl.sv */
// Controller state machine of the modulator cell update unit.
module mcu_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mcu_pkg::mcu_cmd_type cmd
);
   import mcu_pkg::*;

   mcu_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // The result waits here until the output register has room.
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hw/rtl/mcu_dp.sv */
// Datapath of the modulator cell update unit: settings, per-type store and update arithmetic.
module mcu_dp #(
   parameter int NUM_CHANNELS     = mcu_pkg::DEF_NUM_CHANNELS,
   parameter int MAX_WIDTH        = mcu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT       = mcu_pkg::DEF_MAX_HEIGHT,
   parameter int AREA_GROW_STEP   = mcu_pkg::DEF_AREA_GROW_STEP,
   parameter int AREA_SHRINK_STEP = mcu_pkg::DEF_AREA_SHRINK_STEP,
   parameter int MAX_CONC         = mcu_pkg::DEF_MAX_CONC
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mcu_pkg::mcu_cmd_type               cmd,
   input  logic [mcu_pkg::CH_W-1:0]           req_channel,
   input  logic signed [mcu_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                               csr_we,
   input  logic [mcu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mcu_pkg::CSR_W-1:0]          csr_wdata,
   output logic [mcu_pkg::Q_W-1:0]            rsp_level_out,
   output logic [mcu_pkg::Q_W-1:0]            rsp_conc_out,
   output logic [mcu_pkg::AREA_W-1:0]         rsp_width_out,
   output logic [mcu_pkg::AREA_W-1:0]         rsp_height_out,
   output logic                               rsp_window_error
);
   import mcu_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   typedef struct packed {
      logic [Q_W-1:0]    level;
      logic [Q_W-1:0]    conc;
      logic [AREA_W-1:0] width;
      logic [AREA_W-1:0] height;
   } mcu_entry_type;

   localparam logic [Q_W:0]    CONC_CAP   = (Q_W+1)'(MAX_CONC);
   localparam logic [AREA_W:0] WIDTH_CAP  = (AREA_W+1)'(MAX_WIDTH);
   localparam logic [AREA_W:0] HEIGHT_CAP = (AREA_W+1)'(MAX_HEIGHT);
   localparam logic [AREA_W:0] GROW       = (AREA_W+1)'(AREA_GROW_STEP);
   localparam logic [AREA_W-1:0] SHRINK   = AREA_W'(AREA_SHRINK_STEP);

   // Settings.
   logic [Q_W-1:0]             level_gain_ff, level_drop_ff;
   logic [Q_W-1:0]             produce_thr_ff, reduce_thr_ff;
   logic [Q_W-1:0]             conc_gain_ff, conc_drop_ff;
   logic signed [SAMPLE_W-1:0] window_low_ff, window_high_ff;

   // Per-type store and its valid bits.
   mcu_entry_type               mem [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0]     valid_ff;

   logic [IDX_W-1:0]            req_idx;
   logic                        req_in_range;

   logic [IDX_W-1:0]            idx_ff;
   logic                        in_range_ff;
   logic signed [SAMPLE_W-1:0]  sample_ff;
   mcu_entry_type               rd_ff;
   logic                        rd_valid_ff;

   mcu_entry_type               cur, upd;
   logic                        win_err, in_win;
   logic [Q_W:0]                lv_sum, cc_sum;
   logic [Q_W-1:0]              lv_up, lv_dn, cc_up, cc_dn;
   logic [AREA_W:0]             w_sum, h_sum;
   logic [AREA_W-1:0]           w_up, h_up, w_dn, h_dn;

   mcu_entry_type               out_ff, out_in;
   logic                        err_ff, err_in;

   assign req_idx      = IDX_W'(req_channel);
   assign req_in_range = (32'(req_channel) < NUM_CHANNELS);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_gain_ff  <= 15'd16384;
         level_drop_ff  <= 15'd16384;
         produce_thr_ff <= 15'd8192;
         reduce_thr_ff  <= 15'd8192;
         conc_gain_ff   <= 15'd16;
         conc_drop_ff   <= 15'd82;
         window_low_ff  <= 16'sd14746;
         window_high_ff <= 16'sd16384;
      end else if (csr_we) begin
         unique case (mcu_cfg_type'(csr_index))
            CFG_LEVEL_GAIN:  level_gain_ff  <= csr_wdata[Q_W-1:0];
            CFG_LEVEL_DROP:  level_drop_ff  <= csr_wdata[Q_W-1:0];
            CFG_PRODUCE_THR: produce_thr_ff <= csr_wdata[Q_W-1:0];
            CFG_REDUCE_THR:  reduce_thr_ff  <= csr_wdata[Q_W-1:0];
            CFG_CONC_GAIN:   conc_gain_ff   <= csr_wdata[Q_W-1:0];
            CFG_CONC_DROP:   conc_drop_ff   <= csr_wdata[Q_W-1:0];
            CFG_WINDOW_LOW:  window_low_ff  <= csr_wdata;
            CFG_WINDOW_HIGH: window_high_ff <= csr_wdata;
            default:         window_high_ff <= csr_wdata;
         endcase
      end
   end

   // Request capture and registered store read.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         idx_ff      <= req_idx;
         in_range_ff <= req_in_range;
         sample_ff   <= req_sample;
         rd_ff       <= mem[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rd_valid_ff <= req_in_range && valid_ff[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && in_range_ff) begin
         mem[idx_ff] <= upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.commit && in_range_ff) begin
         valid_ff[idx_ff] <= 1'b1;
      end
   end

   // An entry never written reads as zero.
   assign cur = rd_valid_ff ? rd_ff : '0;

   assign win_err = (window_low_ff >= window_high_ff);
   assign in_win  = (sample_ff >= window_low_ff) && (sample_ff <= window_high_ff);

   assign lv_sum = {1'b0, cur.level} + {1'b0, level_gain_ff};
   assign lv_up  = (lv_sum > {1'b0, Q_ONE}) ? Q_ONE : lv_sum[Q_W-1:0];
   assign lv_dn  = (cur.level > level_drop_ff) ? (cur.level - level_drop_ff) : '0;

   assign cc_sum = {1'b0, cur.conc} + {1'b0, conc_gain_ff};
   assign cc_up  = (cc_sum > CONC_CAP) ? CONC_CAP[Q_W-1:0] : cc_sum[Q_W-1:0];
   assign cc_dn  = (cur.conc > conc_drop_ff) ? (cur.conc - conc_drop_ff) : '0;

   assign w_sum = {1'b0, cur.width} + GROW;
   assign h_sum = {1'b0, cur.height} + GROW;
   assign w_up  = (w_sum > WIDTH_CAP) ? WIDTH_CAP[AREA_W-1:0] : w_sum[AREA_W-1:0];
   assign h_up  = (h_sum > HEIGHT_CAP) ? HEIGHT_CAP[AREA_W-1:0] : h_sum[AREA_W-1:0];
   assign w_dn  = (cur.width > SHRINK) ? (cur.width - SHRINK) : '0;
   assign h_dn  = (cur.height > SHRINK) ? (cur.height - SHRINK) : '0;

   always_comb begin
      upd = cur;
      priority if (win_err) begin
         upd = cur;
      end else if (in_win) begin
         upd.level = lv_up;
         if (lv_up >= produce_thr_ff) begin
            upd.conc   = cc_up;
            upd.width  = w_up;
            upd.height = h_up;
         end
      end else begin
         upd.level = lv_dn;
         if (lv_dn <= reduce_thr_ff) begin
            upd.conc = cc_dn;
            // Once the concentration is used up the area collapses.
            if (cc_dn != '0) begin
               upd.width  = w_dn;
               upd.height = h_dn;
            end else begin
               upd.width  = '0;
               upd.height = '0;
            end
         end
      end
   end

   always_comb begin
      if (in_range_ff) begin
         out_in = upd;
         err_in = win_err;
      end else begin
         out_in = '0;
         err_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_ff <= out_in;
         err_ff <= err_in;
      end
   end

   assign rsp_level_out    = out_ff.level;
   assign rsp_conc_out     = out_ff.conc;
   assign rsp_width_out    = out_ff.width;
   assign rsp_height_out   = out_ff.height;
   assign rsp_window_error = err_ff;

endmodule

/* hw/rtl/modulator_cell_update_unit.sv */
// Modulator cell update unit: per-type activation level, concentration and area update.
//
// A request beat carries a modulator type (req_channel) and an activation sample
// (req_sample). It is taken at a clock edge with req_valid high and req_stall low.
// Each type keeps a level, a concentration, a width and a height; the beat updates
// that entry and returns one response beat with the new values and a window error
// flag. The user is to write settings through csr_we, csr_index and csr_wdata only
// while idle; the block itself does not enforce this. An item goes through a load
// step, which reads its store entry into a register, and an update step, which
// computes, writes the entry back and loads the output register. The response is
// valid from the cycle after the output register is loaded, and no new request is
// taken before the item has been written back. The output register lets the next
// request be taken while a response still waits. If the receiver holds rsp_stall
// high, the response and its fields stay put and a finished item waits in the
// update step, stalling the request side, until there is room. Reset clears all
// stored entries to zero (valid bits), restores the settings to their defaults and
// empties the output; it takes effect at the next rising clock edge.
module modulator_cell_update_unit #(
   parameter int NUM_CHANNELS     = mcu_pkg::DEF_NUM_CHANNELS,
   parameter int MAX_WIDTH        = mcu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT       = mcu_pkg::DEF_MAX_HEIGHT,
   parameter int AREA_GROW_STEP   = mcu_pkg::DEF_AREA_GROW_STEP,
   parameter int AREA_SHRINK_STEP = mcu_pkg::DEF_AREA_SHRINK_STEP,
   parameter int MAX_CONC         = mcu_pkg::DEF_MAX_CONC
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mcu_pkg::CH_W-1:0]            req_channel,
   input  logic signed [mcu_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mcu_pkg::Q_W-1:0]             rsp_level_out,
   output logic [mcu_pkg::Q_W-1:0]             rsp_conc_out,
   output logic [mcu_pkg::AREA_W-1:0]          rsp_width_out,
   output logic [mcu_pkg::AREA_W-1:0]          rsp_height_out,
   output logic                                rsp_window_error,
   input  logic                                csr_we,
   input  logic [mcu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mcu_pkg::CSR_W-1:0]           csr_wdata
);
   import mcu_pkg::*;

   mcu_cmd_type cmd;

   mcu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   mcu_dp #(
      .NUM_CHANNELS     (NUM_CHANNELS),
      .MAX_WIDTH        (MAX_WIDTH),
      .MAX_HEIGHT       (MAX_HEIGHT),
      .AREA_GROW_STEP   (AREA_GROW_STEP),
      .AREA_SHRINK_STEP (AREA_SHRINK_STEP),
      .MAX_CONC         (MAX_CONC)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_channel      (req_channel),
      .req_sample       (req_sample),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_level_out    (rsp_level_out),
      .rsp_conc_out     (rsp_conc_out),
      .rsp_width_out    (rsp_width_out),
      .rsp_height_out   (rsp_height_out),
      .rsp_window_error (rsp_window_error)
   );

endmodule

/* hw/rtl/mcu_checker.sv */
// Port-level checks of the modulator cell update unit and their binding.
module mcu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [14:0] rsp_level_out,
   input logic [14:0] rsp_conc_out,
   input logic [9:0]  rsp_width_out,
   input logic [9:0]  rsp_height_out,
   input logic        rsp_window_error
);

   // The output is empty straight after reset.
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // A taken request keeps the request side stalled while it is worked on.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while the previous one is in progress");

   // The activation level never exceeds one.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level_out <= 15'd16384))
      else $error("level above one");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_level_out)
         && $stable(rsp_conc_out) && $stable(rsp_width_out)
         && $stable(rsp_height_out) && $stable(rsp_window_error)))
      else $error("stalled response changed");

endmodule

bind modulator_cell_update_unit mcu_checker u_mcu_checker (.*);

/* bench/cell_update_checker.sv */
// Checker for the modulator cell update unit: predicts every response beat and compares it.
`timescale 1ns / 100ps

module cell_update_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [mcu_pkg::CH_W-1:0]            req_channel,
   input  logic signed [mcu_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [mcu_pkg::Q_W-1:0]             rsp_level_out,
   input  logic [mcu_pkg::Q_W-1:0]             rsp_conc_out,
   input  logic [mcu_pkg::AREA_W-1:0]          rsp_width_out,
   input  logic [mcu_pkg::AREA_W-1:0]          rsp_height_out,
   input  logic                                rsp_window_error,
   input  logic                                csr_we,
   input  logic [mcu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mcu_pkg::CSR_W-1:0]           csr_wdata,
   output int                                  fail_count,
   output int                                  cells_waiting
);
   import mcu_pkg::*;

   typedef struct packed {
      logic [Q_W-1:0]    level;
      logic [Q_W-1:0]    conc;
      logic [AREA_W-1:0] width;
      logic [AREA_W-1:0] height;
      logic              win_err;
   } cell_result_type;

   logic [Q_W-1:0]             gain_lv, drop_lv, thr_prod, thr_red, gain_cc, drop_cc;
   logic signed [SAMPLE_W-1:0] win_lo, win_hi;

   logic [Q_W-1:0]    level_mem  [DEF_NUM_CHANNELS];
   logic [Q_W-1:0]    conc_mem   [DEF_NUM_CHANNELS];
   logic [AREA_W-1:0] width_mem  [DEF_NUM_CHANNELS];
   logic [AREA_W-1:0] height_mem [DEF_NUM_CHANNELS];

   cell_result_type pending_cells[$];
   cell_result_type oldest;

   initial begin
      fail_count    = 0;
      cells_waiting = 0;
   end

   function automatic int unsigned sat_add(input int unsigned a, input int unsigned b,
                                           input int unsigned cap);
      int unsigned s;
      s = a + b;
      return (s > cap) ? cap : s;
   endfunction

   function automatic int unsigned sat_sub(input int unsigned a, input int unsigned b);
      return (a > b) ? a - b : 0;
   endfunction

   // Applies one request beat to the stored entry of its type and returns the new values.
   function automatic cell_result_type predict_cell(input logic [CH_W-1:0] ch,
                                                    input logic signed [SAMPLE_W-1:0] s);
      int unsigned     lv, cc, w, h;
      cell_result_type r;
      r = '0;
      if (ch >= DEF_NUM_CHANNELS) return r;
      lv = level_mem[ch];
      cc = conc_mem[ch];
      w  = width_mem[ch];
      h  = height_mem[ch];
      if (win_lo >= win_hi) begin
         r.win_err = 1'b1;
      end else if (s >= win_lo && s <= win_hi) begin
         lv = sat_add(lv, gain_lv, Q_ONE);
         if (lv >= thr_prod) begin
            cc = sat_add(cc, gain_cc, DEF_MAX_CONC);
            w  = sat_add(w, DEF_AREA_GROW_STEP, DEF_MAX_WIDTH);
            h  = sat_add(h, DEF_AREA_GROW_STEP, DEF_MAX_HEIGHT);
         end
      end else begin
         lv = sat_sub(lv, drop_lv);
         if (lv <= thr_red) begin
            cc = sat_sub(cc, drop_cc);
            if (cc > 0) begin
               w = sat_sub(w, DEF_AREA_SHRINK_STEP);
               h = sat_sub(h, DEF_AREA_SHRINK_STEP);
            end else begin
               w = 0;
               h = 0;
            end
         end
      end
      r.level  = lv[Q_W-1:0];
      r.conc   = cc[Q_W-1:0];
      r.width  = w[AREA_W-1:0];
      r.height = h[AREA_W-1:0];
      level_mem[ch]  = r.level;
      conc_mem[ch]   = r.conc;
      width_mem[ch]  = r.width;
      height_mem[ch] = r.height;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [Q_W-1:0] want,
                              input logic [Q_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gain_lv  = 15'd16384;
         drop_lv  = 15'd16384;
         thr_prod = 15'd8192;
         thr_red  = 15'd8192;
         gain_cc  = 15'd16;
         drop_cc  = 15'd82;
         win_lo   = 16'sd14746;
         win_hi   = 16'sd16384;
         for (int i = 0; i < DEF_NUM_CHANNELS; i++) begin
            level_mem[i]  = '0;
            conc_mem[i]   = '0;
            width_mem[i]  = '0;
            height_mem[i] = '0;
         end
         pending_cells.delete();
      end else begin
         // The response side is looked at first: a beat leaving now belongs to an older request.
         if (rsp_valid && !rsp_stall) begin
            if (pending_cells.size() == 0) begin
               $error("response beat with no request waiting for it");
               fail_count++;
            end else begin
               oldest = pending_cells.pop_front();
               check_field("level_out", oldest.level, rsp_level_out);
               check_field("conc_out", oldest.conc, rsp_conc_out);
               check_field("width_out", Q_W'(oldest.width), Q_W'(rsp_width_out));
               check_field("height_out", Q_W'(oldest.height), Q_W'(rsp_height_out));
               check_field("window_error", Q_W'(oldest.win_err), Q_W'(rsp_window_error));
            end
         end
         if (csr_we) begin
            case (csr_index)
               CFG_LEVEL_GAIN:  gain_lv  = csr_wdata[Q_W-1:0];
               CFG_LEVEL_DROP:  drop_lv  = csr_wdata[Q_W-1:0];
               CFG_PRODUCE_THR: thr_prod = csr_wdata[Q_W-1:0];
               CFG_REDUCE_THR:  thr_red  = csr_wdata[Q_W-1:0];
               CFG_CONC_GAIN:   gain_cc  = csr_wdata[Q_W-1:0];
               CFG_CONC_DROP:   drop_cc  = csr_wdata[Q_W-1:0];
               CFG_WINDOW_LOW:  win_lo   = csr_wdata;
               default:         win_hi   = csr_wdata;
            endcase
         end
         if (req_valid && !req_stall)
            pending_cells.push_back(predict_cell(req_channel, req_sample));
      end
      cells_waiting = pending_cells.size();
   end

endmodule

/* bench/tb.sv */
// Top of the bench: drives request beats, settings and response stalls, and gives the verdict.
`timescale 1ns / 100ps

module tb;
   import mcu_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [CH_W-1:0]            req_channel;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [Q_W-1:0]             rsp_level_out;
   logic [Q_W-1:0]             rsp_conc_out;
   logic [AREA_W-1:0]          rsp_width_out;
   logic [AREA_W-1:0]          rsp_height_out;
   logic                       rsp_window_error;
   logic                       csr_we;
   logic [CSR_IDX_W-1:0]       csr_index;
   logic [CSR_W-1:0]           csr_wdata;

   int fail_count;
   int cells_waiting;
   int cycles;
   bit send_gaps;
   bit sink_gaps;
   int cur_lo;
   int cur_hi;

   modulator_cell_update_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_channel      (req_channel),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_level_out    (rsp_level_out),
      .rsp_conc_out     (rsp_conc_out),
      .rsp_width_out    (rsp_width_out),
      .rsp_height_out   (rsp_height_out),
      .rsp_window_error (rsp_window_error),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   cell_update_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_channel      (req_channel),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_level_out    (rsp_level_out),
      .rsp_conc_out     (rsp_conc_out),
      .rsp_width_out    (rsp_width_out),
      .rsp_height_out   (rsp_height_out),
      .rsp_window_error (rsp_window_error),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .cells_waiting    (cells_waiting)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // The receiver holds off at random whether or not a response beat is on offer.
   always @(negedge clock)
      rsp_stall <= sink_gaps && ($urandom_range(99) < 27);

   task automatic send_sample(input logic [CH_W-1:0] ch, input logic signed [SAMPLE_W-1:0] s);
      while (send_gaps && $urandom_range(99) < 27) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= s;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic write_reg(input mcu_cfg_type idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_W-1:0];
      if (idx == CFG_WINDOW_LOW) cur_lo = $signed(value[CSR_W-1:0]);
      if (idx == CFG_WINDOW_HIGH) cur_hi = $signed(value[CSR_W-1:0]);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // Lets every outstanding beat come back, then idles on so that the pipeline can empty.
   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (cells_waiting != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] make_sample(input bit in_win);
      int         v;
      logic [15:0] raw;
      raw = 16'($urandom);
      v   = $signed(raw);
      if (cur_lo < cur_hi) begin
         if (in_win) begin
            case ($urandom_range(5))
               0:       v = cur_lo;
               1:       v = cur_hi;
               default: v = cur_lo + int'($urandom_range(cur_hi - cur_lo));
            endcase
         end else begin
            case ($urandom_range(4))
               0: if (cur_lo > -32768) v = cur_lo - 1;
               1: if (cur_hi < 32767) v = cur_hi + 1;
               default: ;
            endcase
            for (int k = 0; k < 8 && v >= cur_lo && v <= cur_hi; k++) begin
               raw = 16'($urandom);
               v   = $signed(raw);
            end
         end
      end
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic int pick_q(input int sel);
      case (sel)
         0:       return 0;
         1:       return 16384;
         2:       return 32767;
         3:       return $urandom_range(300);
         4:       return $urandom_range(32767);
         default: return $urandom_range(16384);
      endcase
   endfunction

   task automatic random_settings;
      int         lo, hi, t;
      logic [15:0] raw;
      write_reg(CFG_LEVEL_GAIN, pick_q($urandom_range(7)));
      write_reg(CFG_LEVEL_DROP, pick_q($urandom_range(7)));
      write_reg(CFG_PRODUCE_THR, pick_q($urandom_range(7)));
      write_reg(CFG_REDUCE_THR, pick_q($urandom_range(7)));
      write_reg(CFG_CONC_GAIN, pick_q($urandom_range(7)));
      write_reg(CFG_CONC_DROP, pick_q($urandom_range(7)));
      raw = 16'($urandom);
      lo  = $signed(raw);
      raw = 16'($urandom);
      hi  = $signed(raw);
      if ($urandom_range(3) == 0) lo = -32768;
      if ($urandom_range(3) == 0) hi = 32767;
      // Now and then the bounds are left unordered on purpose, so the window may be empty.
      if ($urandom_range(9) != 0) begin
         if (lo > hi) begin
            t  = lo;
            lo = hi;
            hi = t;
         end
         if (lo == hi) begin
            if (hi < 32767) hi = hi + 1;
            else lo = lo - 1;
         end
      end
      write_reg(CFG_WINDOW_LOW, lo);
      write_reg(CFG_WINDOW_HIGH, hi);
   endtask

   initial begin
      int in_pct;
      int span;
      int base;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_channel = '0;
      req_sample  = '0;
      rsp_stall   = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CFG_LEVEL_GAIN;
      csr_wdata   = '0;
      cycles      = 0;
      send_gaps   = 1'b1;
      sink_gaps   = 1'b1;
      cur_lo      = 14746;
      cur_hi      = 16384;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Defaults: window bounds, just outside them and the extremes of the sample.
      for (int c = 0; c < DEF_NUM_CHANNELS; c++) send_sample(CH_W'(c), 16'sd16384);
      send_sample(3'd0, 16'sd14746);
      send_sample(3'd0, 16'sd14745);
      send_sample(3'd1, 16'sd16385);
      send_sample(3'd2, -16'sd32768);
      send_sample(3'd2, 16'sd32767);
      send_sample(3'd1, 16'sd0);

      drain;
      write_reg(CFG_WINDOW_LOW, -32768);
      write_reg(CFG_WINDOW_HIGH, 32767);
      send_sample(3'd7, -16'sd32768);
      send_sample(3'd7, 16'sd32767);

      // Empty window, with equal bounds and with crossed ones.
      drain;
      write_reg(CFG_WINDOW_LOW, 100);
      write_reg(CFG_WINDOW_HIGH, 100);
      send_sample(3'd7, 16'sd100);
      send_sample(3'd0, -16'sd5);
      drain;
      write_reg(CFG_WINDOW_LOW, 32767);
      write_reg(CFG_WINDOW_HIGH, -32768);
      send_sample(3'd5, 16'sd0);

      // Growth on one type, until concentration and area reach their ceilings.
      drain;
      write_reg(CFG_LEVEL_GAIN, 16384);
      write_reg(CFG_PRODUCE_THR, 0);
      write_reg(CFG_CONC_GAIN, 200);
      write_reg(CFG_WINDOW_LOW, 0);
      write_reg(CFG_WINDOW_HIGH, 8192);
      for (int i = 0; i < 110; i++) send_sample(3'd3, make_sample(1'b1));

      // Depletion on the same type: the area first shrinks, then is cleared.
      drain;
      write_reg(CFG_LEVEL_DROP, 4096);
      write_reg(CFG_REDUCE_THR, 16384);
      write_reg(CFG_CONC_DROP, 300);
      for (int i = 0; i < 70; i++) send_sample(3'd3, make_sample(1'b0));

      for (int p = 0; p < 6; p++) begin
         drain;
         random_settings;
         send_gaps = (p != 3);
         sink_gaps = (p != 3);
         case ($urandom_range(2))
            0:       in_pct = 90;
            1:       in_pct = 50;
            default: in_pct = 10;
         endcase
         case ($urandom_range(2))
            0:       span = 0;
            1:       span = 1;
            default: span = 7;
         endcase
         base = $urandom_range(7 - span);
         for (int i = 0; i < 45; i++)
            send_sample(CH_W'(base + int'($urandom_range(span))),
                        make_sample($urandom_range(99) < in_pct));
      end
      send_gaps = 1'b1;
      sink_gaps = 1'b1;

      drain;
      repeat (8) @(negedge clock);
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
